// ===== hw/rtl/chw_pkg.sv =====
// Package for the chained hash word set.
// Sizes, request kind and status codes, lowercase helper. No dependencies.
`default_nettype none
package chw_pkg;
    localparam int MAX_WORD_LEN = 45;
    localparam int BUCKETS      = 50;
    localparam int CAPACITY     = 1024;

    localparam int HASH_W  = 64;
    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam int HASH_SHIFT = 5;

    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int WIDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_W = $clog2(CAPACITY + 1);
    localparam int EIDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ADDR_W = (CAPACITY * MAX_WORD_LEN > 1) ?
                            $clog2(CAPACITY * MAX_WORD_LEN) : 1;
    localparam int TOTAL_W = 11;

    localparam logic [NODE_W-1:0] EMPTY_MARK = NODE_W'(CAPACITY);

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_LOOKUP = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_TOOLONG = 2'd2;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/chw_divmod.sv =====
// Remainder of the 64-bit hash by the bucket count: 16-bit folding, a second
// fold and a reciprocal multiplication. Depends on chw_pkg.
`default_nettype none
module chw_divmod
    import chw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    output logic                   o_done,
    output logic [BKT_W-1:0]       o_rem
);
    localparam int     K16    = 65536 % BUCKETS;
    localparam int     K32    = (K16 * K16) % BUCKETS;
    localparam int     K48    = (K32 * K16) % BUCKETS;
    localparam int     K12    = 4096 % BUCKETS;
    localparam longint S1_MAX = 64'd65535 * 64'(1 + K16 + K32 + K48);
    localparam int     S1_W   = $clog2(S1_MAX + 1);
    localparam longint T_MAX  = 64'd4095 + (S1_MAX >> 12) * 64'(K12);
    localparam int     T_W    = $clog2(T_MAX + 1);
    localparam int     SH     = T_W + $clog2(BUCKETS);
    localparam longint RECIP  = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam int     P_W    = T_W + $clog2(RECIP + 1);

    logic [S1_W-1:0]  r_s1;
    logic [T_W-1:0]   r_t;
    logic [T_W-1:0]   r_tq;
    logic [T_W-1:0]   r_q;
    logic [BKT_W-1:0] r_rem;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             r_done;
    logic [S1_W-1:0]  n_s1;
    logic [T_W-1:0]   n_t;
    logic [P_W-1:0]   n_prod;

    assign n_s1 = S1_W'(i_dividend[15:0])
                + S1_W'(i_dividend[31:16]) * S1_W'(K16)
                + S1_W'(i_dividend[47:32]) * S1_W'(K32)
                + S1_W'(i_dividend[63:48]) * S1_W'(K48);
    assign n_t    = T_W'(r_s1[11:0]) + T_W'(r_s1[S1_W-1:12]) * T_W'(K12);
    assign n_prod = P_W'(r_t) * P_W'(RECIP);

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_t   <= n_t;
        r_tq  <= r_t;
        r_q   <= T_W'(n_prod >> SH);
        r_rem <= BKT_W'(r_tq - r_q * T_W'(BUCKETS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== hw/rtl/chained_hash_word_set.sv =====
// Top level of the chained hash word set: sequencer and the table memories.
// Depends on chw_pkg and chw_divmod.
//
//  channel  | handshake            | payload
//  request  | start, busy          | i_kind, i_ch, i_last
//  result   | o_done (one cycle)   | o_found, o_word_total, o_status
//
// A mid-word byte or a clear is taken without leaving idle; a clear answers the next cycle.
// A last byte passes the remainder unit to its bucket head (S_MOD, S_HRD, S_HUSE);
// an insert then copies each byte (S_CPRD, S_CPWR) and links it (S_LINK), while
// a lookup checks each node (S_NODE, S_NCHK) and byte (S_CRD, S_CCMP), then answers.
// busy is high while the sequencer is out of idle with a completed word. Reset is synchronous, low;
// it empties all buckets at once through per-bucket valid bits.
// Results cannot be stalled.
`default_nettype none
module chained_hash_word_set
    import chw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_kind,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_last,
    output logic                    busy,
    output logic                    o_done,
    output logic                    o_found,
    output logic [TOTAL_W-1:0]      o_word_total,
    output logic [1:0]              o_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_HRD, S_HUSE, S_CPRD, S_CPWR, S_LINK,
        S_NODE, S_NCHK, S_CRD, S_CCMP
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_wlen;
    logic               r_ovl;
    logic [HASH_W-1:0]  r_hash;
    logic [NODE_W-1:0]  r_count;
    logic [BUCKETS-1:0] r_hvalid;
    t_kind              r_kind;
    logic [BKT_W-1:0]   r_bkt;
    logic [NODE_W-1:0]  r_head;
    logic [NODE_W-1:0]  r_node;
    logic [NODE_W-1:0]  r_steps;
    logic [ADDR_W-1:0]  r_base;
    logic [LEN_W-1:0]   r_idx;
    logic               r_done;
    logic               r_found;
    t_status            r_status;

    logic [7:0]         wbuf [MAX_WORD_LEN];
    logic [7:0]         echars [CAPACITY * MAX_WORD_LEN];
    logic [LEN_W-1:0]   elen [CAPACITY];
    logic [NODE_W-1:0]  elink [CAPACITY];
    logic [EIDX_W-1:0]  heads [BUCKETS];

    logic [7:0]         r_wbuf_q;
    logic [7:0]         r_ech_q;
    logic [LEN_W-1:0]   r_elen_q;
    logic [NODE_W-1:0]  r_elink_q;
    logic [EIDX_W-1:0]  r_head_q;

    logic               n_accept;
    logic [7:0]         n_lc;
    logic [HASH_W-1:0]  n_hash;
    logic               n_ovl;
    logic               n_wbuf_we;
    logic [ADDR_W-1:0]  n_eaddr;
    logic               n_div_start;
    logic               n_div_done;
    logic [BKT_W-1:0]   n_div_rem;

    assign n_accept  = start && !busy;
    assign n_lc      = to_lower(i_ch);
    assign n_hash    = (r_hash << HASH_SHIFT) + r_hash + HASH_W'(n_lc);
    assign n_ovl     = r_ovl || (r_wlen == LEN_W'(MAX_WORD_LEN));
    assign n_wbuf_we = n_accept && (i_kind == KIND_INSERT || i_kind == KIND_LOOKUP)
                       && (r_wlen < LEN_W'(MAX_WORD_LEN));
    assign n_eaddr   = r_base + ADDR_W'(r_idx);
    assign n_div_start = n_accept && i_last && !n_ovl
                         && (i_kind == KIND_INSERT || i_kind == KIND_LOOKUP);

    chw_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_hash),
        .o_done     (n_div_done),
        .o_rem      (n_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (n_wbuf_we) begin
            wbuf[r_wlen[WIDX_W-1:0]] <= n_lc;
        end
        r_wbuf_q <= wbuf[r_idx[WIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CPWR) begin
            echars[n_eaddr] <= r_wbuf_q;
        end
        r_ech_q <= echars[n_eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LINK) begin
            elen[r_count[EIDX_W-1:0]]  <= r_wlen;
            elink[r_count[EIDX_W-1:0]] <= r_head;
        end
        r_elen_q  <= elen[r_node[EIDX_W-1:0]];
        r_elink_q <= elink[r_node[EIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LINK) begin
            heads[r_bkt] <= r_count[EIDX_W-1:0];
        end
        r_head_q <= heads[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wlen   <= '0;
            r_ovl    <= 1'b0;
            r_hash   <= HASH_SEED;
            r_count  <= '0;
            r_hvalid <= '0;
            r_done   <= 1'b0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (i_kind == KIND_CLEAR) begin
                            r_hvalid <= '0;
                            r_count  <= '0;
                            r_wlen   <= '0;
                            r_ovl    <= 1'b0;
                            r_hash   <= HASH_SEED;
                            r_done   <= 1'b1;
                            r_found  <= 1'b0;
                            r_status <= ST_OK;
                        end else if (i_kind == KIND_INSERT || i_kind == KIND_LOOKUP) begin
                            if (!i_last) begin
                                r_hash <= n_hash;
                                r_ovl  <= n_ovl;
                                if (!n_ovl) begin
                                    r_wlen <= r_wlen + 1'b1;
                                end
                            end else begin
                                r_hash <= HASH_SEED;
                                r_ovl  <= 1'b0;
                                r_kind <= i_kind;
                                if (n_ovl) begin
                                    r_wlen   <= '0;
                                    r_done   <= 1'b1;
                                    r_found  <= 1'b0;
                                    r_status <= ST_TOOLONG;
                                end else begin
                                    r_wlen  <= r_wlen + 1'b1;
                                    r_state <= S_MOD;
                                end
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (n_div_done) begin
                        r_bkt   <= n_div_rem;
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HUSE;
                end
                S_HUSE: begin
                    r_head  <= r_hvalid[r_bkt] ? NODE_W'(r_head_q) : EMPTY_MARK;
                    r_node  <= r_hvalid[r_bkt] ? NODE_W'(r_head_q) : EMPTY_MARK;
                    r_steps <= '0;
                    r_idx   <= '0;
                    if (r_kind == KIND_INSERT) begin
                        if (r_count == NODE_W'(CAPACITY)) begin
                            r_wlen   <= '0;
                            r_done   <= 1'b1;
                            r_found  <= 1'b0;
                            r_status <= ST_FULL;
                            r_state  <= S_IDLE;
                        end else begin
                            r_base  <= ADDR_W'(r_count) * ADDR_W'(MAX_WORD_LEN);
                            r_state <= S_CPRD;
                        end
                    end else begin
                        r_state <= S_NODE;
                    end
                end
                S_CPRD: begin
                    r_state <= S_CPWR;
                end
                S_CPWR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_wlen) begin
                        r_state <= S_LINK;
                    end else begin
                        r_state <= S_CPRD;
                    end
                end
                S_LINK: begin
                    r_hvalid[r_bkt] <= 1'b1;
                    r_count  <= r_count + 1'b1;
                    r_wlen   <= '0;
                    r_done   <= 1'b1;
                    r_found  <= 1'b0;
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                end
                S_NODE: begin
                    r_idx  <= '0;
                    r_base <= ADDR_W'(r_node[EIDX_W-1:0]) * ADDR_W'(MAX_WORD_LEN);
                    if (r_node >= NODE_W'(CAPACITY) || r_steps >= r_count) begin
                        r_wlen   <= '0;
                        r_done   <= 1'b1;
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    if (r_elen_q == r_wlen) begin
                        r_state <= S_CRD;
                    end else begin
                        r_node  <= r_elink_q;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_NODE;
                    end
                end
                S_CRD: begin
                    r_state <= S_CCMP;
                end
                S_CCMP: begin
                    if (r_ech_q != r_wbuf_q) begin
                        r_node  <= r_elink_q;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_NODE;
                    end else if (r_idx + 1'b1 == r_wlen) begin
                        r_wlen   <= '0;
                        r_done   <= 1'b1;
                        r_found  <= 1'b1;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_word_total = TOTAL_W'(r_count);
    assign o_status     = r_status;
endmodule
`default_nettype wire

// ===== tb/sv/chw_checker.sv =====
// Checker for the chained hash word set: watches requests and results.
// Predicts each result from its own copy of the word set. Depends on chw_pkg.
module chw_checker
    import chw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         i_kind,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_last,
    input  wire logic               o_done,
    input  wire logic               o_found,
    input  wire logic [TOTAL_W-1:0] o_word_total,
    input  wire logic [1:0]         o_status,
    output int                      o_errors,
    output int                      o_pending
);
    typedef struct packed {
        logic               found;
        logic [TOTAL_W-1:0] total;
        t_status            status;
    } t_answer;

    t_answer    answers[$];
    logic [7:0] cur_word[MAX_WORD_LEN];
    int         cur_len;
    logic       too_long;
    logic [63:0] hash;
    int         heads[BUCKETS];
    logic [7:0] set_chars[CAPACITY][MAX_WORD_LEN];
    int         set_lens[CAPACITY];
    int         set_links[CAPACITY];
    int         set_count;

    function automatic logic chain_match(input int bkt);
        int  node;
        int  steps;
        logic same;
        node  = heads[bkt];
        steps = 0;
        while (node < CAPACITY && steps < set_count) begin
            if (set_lens[node] == cur_len) begin
                same = 1'b1;
                for (int i = 0; i < cur_len; i++) begin
                    if (set_chars[node][i] != cur_word[i]) same = 1'b0;
                end
                if (same) return 1'b1;
            end
            node = set_links[node];
            steps++;
        end
        return 1'b0;
    endfunction

    task automatic drop_word();
        cur_len  = 0;
        too_long = 1'b0;
        hash     = 64'd5381;
    endtask

    task automatic empty_set();
        for (int b = 0; b < BUCKETS; b++) heads[b] = CAPACITY;
        set_count = 0;
    endtask

    task automatic predict(input logic [1:0] k, input logic [7:0] raw, input logic l);
        t_answer    a;
        logic [7:0] c;
        int         bkt;
        a = '0;
        c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
        if (k == KIND_CLEAR) begin
            empty_set();
            drop_word();
            answers.push_back(a);
        end else if (k == KIND_INSERT || k == KIND_LOOKUP) begin
            if (cur_len < MAX_WORD_LEN) begin
                cur_word[cur_len] = c;
                cur_len++;
            end else begin
                too_long = 1'b1;
            end
            hash = (hash << 5) + hash + 64'(c);
            if (l) begin
                if (too_long) begin
                    a.status = ST_TOOLONG;
                end else begin
                    bkt = int'(hash % 64'(BUCKETS));
                    if (k == KIND_INSERT) begin
                        if (set_count >= CAPACITY) begin
                            a.status = ST_FULL;
                        end else begin
                            for (int i = 0; i < cur_len; i++)
                                set_chars[set_count][i] = cur_word[i];
                            set_lens[set_count]  = cur_len;
                            set_links[set_count] = heads[bkt];
                            heads[bkt]           = set_count;
                            set_count++;
                        end
                    end else begin
                        a.found = chain_match(bkt);
                    end
                end
                drop_word();
                a.total = TOTAL_W'(set_count);
                answers.push_back(a);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            answers.delete();
            drop_word();
            empty_set();
        end else begin
            if (o_done) begin
                if (answers.size() == 0) begin
                    $error("unexpected result: found %0d total %0d status %0d",
                           o_found, o_word_total, o_status);
                    o_errors++;
                end else begin
                    exp_a = answers.pop_front();
                    if (o_found !== exp_a.found) begin
                        $error("found: expected %0d, got %0d", exp_a.found, o_found);
                        o_errors++;
                    end
                    if (o_word_total !== exp_a.total) begin
                        $error("word_total: expected %0d, got %0d", exp_a.total,
                               o_word_total);
                        o_errors++;
                    end
                    if (o_status !== exp_a.status) begin
                        $error("status: expected %0d, got %0d", exp_a.status, o_status);
                        o_errors++;
                    end
                end
            end
            if (start && !busy) predict(i_kind, i_ch, i_last);
        end
        o_pending = answers.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the chained hash word set: clock, reset, request stimulus.
// Depends on chw_pkg, chained_hash_word_set and chw_checker.
module tb;
    import chw_pkg::*;

    localparam int WATCH_LIMIT = 300000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [1:0]         i_kind;
    logic [7:0]         i_ch;
    logic               i_last;
    logic               busy;
    logic               o_done;
    logic               o_found;
    logic [TOTAL_W-1:0] o_word_total;
    logic [1:0]         o_status;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    int                 burst_left;
    int                 sent;
    logic [7:0]         pool_w[16][8];
    int                 pool_n[16];
    logic [7:0]         word[64];

    chained_hash_word_set dut (.*);

    chw_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_ch(i_ch), .i_last(i_last), .o_done(o_done),
        .o_found(o_found), .o_word_total(o_word_total), .o_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [1:0] k, input logic [7:0] c, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_kind <= k;
        i_ch   <= c;
        i_last <= l;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic send_word(input logic [1:0] k, input int n, input bit mix);
        logic [1:0] kk;
        for (int i = 0; i < n; i++) begin
            kk = (mix && i < n - 1) ? 2'($urandom_range(0, 1)) : k;
            send(kk, word[i], i == n - 1);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int p;
        int r;
        logic [1:0] k;
        idle_cycles = 0;
        burst_left  = 0;
        sent        = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_kind  = KIND_INSERT;
        i_ch    = 8'h00;
        i_last  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: case folding, edge bytes, clear, unused kind
        word[0] = "A"; word[1] = "Z";
        send_word(KIND_INSERT, 2, 0);
        word[0] = "a"; word[1] = "z";
        send_word(KIND_LOOKUP, 2, 0);
        word[0] = "@"; word[1] = "[";
        send_word(KIND_LOOKUP, 2, 0);
        word[0] = 8'h00; word[1] = 8'hFF;
        send_word(KIND_INSERT, 2, 0);
        send_word(KIND_LOOKUP, 2, 0);
        send_word(KIND_INSERT, 2, 0);
        word[0] = "Q";
        send_word(KIND_LOOKUP, 2, 1);
        send(KIND_UNUSED, 8'h55, 1'b1);
        send(KIND_INSERT, "x", 1'b0);
        send(KIND_CLEAR, 8'hAA, 1'b0);
        word[0] = "a"; word[1] = "z";
        send_word(KIND_LOOKUP, 2, 0);
        send(KIND_CLEAR, 8'h00, 1'b1);
        drain();

        for (int j = 0; j < 16; j++) begin
            pool_n[j] = (j == 0) ? MAX_WORD_LEN : $urandom_range(1, 8);
            for (int i = 0; i < 8; i++) pool_w[j][i] = 8'($urandom_range("a", "f"));
        end

        while (sent < 450) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_LOOKUP;
            if (r < 65) begin
                p = $urandom_range(0, 15);
                n = pool_n[p];
                for (int i = 0; i < n; i++) begin
                    word[i] = pool_w[p][i % 8];
                    if ($urandom_range(0, 1) == 0) word[i] = word[i] - 8'd32;
                end
                send_word(k, n, $urandom_range(0, 9) == 0);
            end else if (r < 85) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) word[i] = 8'($urandom_range(0, 255));
                send_word(k, n, $urandom_range(0, 4) == 0);
            end else if (r < 90) begin
                n = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 4);
                for (int i = 0; i < n; i++) word[i] = 8'($urandom_range(0, 255));
                send_word(k, n, 0);
            end else if (r < 94) begin
                send(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (r < 96) begin
                send(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send(k, 8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 0) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
